// File: rtl/core/mean_and_std_dev_accumulator_macros.svh
// Assertion helpers for the mean and deviation accumulator.
// Each use expands to one labeled concurrent assertion on the rising clock edge,
// disabled while the active-low reset is asserted.
`ifndef MEAN_AND_STD_DEV_ACCUMULATOR_MACROS_SVH
`define MEAN_AND_STD_DEV_ACCUMULATOR_MACROS_SVH

// Same-cycle implication.
`define MSD_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MSD_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/msd_pkg.sv
package msd_pkg;

  // Field and datapath widths
  localparam int unsigned SampleW = 24;
  localparam int unsigned CountW  = 17;
  localparam int unsigned SumW    = 40;
  localparam int unsigned SqSumW  = 64;
  localparam int unsigned SquareW = 48;
  localparam int unsigned WideW   = 80;
  localparam int unsigned DenW    = 32;
  localparam int unsigned RootW   = 64;
  localparam int unsigned IterW   = 7;

  // Samples beyond this count in one sequence are dropped
  localparam logic [CountW-1:0] MaxSamples = 17'd65536;

  // Iteration counts of the shared add/subtract unit per phase
  localparam logic [IterW-1:0] MulCountIters = 7'd17;
  localparam logic [IterW-1:0] SqIters       = 7'd40;
  localparam logic [IterW-1:0] DivVarIters   = 7'd80;
  localparam logic [IterW-1:0] RootIters     = 7'd32;
  localparam logic [IterW-1:0] DivMeanIters  = 7'd40;

  // First trial bit of the bitwise square root
  localparam logic [RootW-1:0] RootFirstBit = RootW'(1) << (RootW - 2);

  typedef enum logic [3:0] {
    SeqIdle,
    SeqLoad,
    SeqMulN,
    SeqMulSq,
    SeqDiff,
    SeqMulDen,
    SeqDivVar,
    SeqRoot,
    SeqDivMean,
    SeqDone
  } seq_state_e;

  // Running sums of one sequence
  typedef struct packed {
    logic signed [SumW-1:0] sum;
    logic [SqSumW-1:0]      sq_sum;
    logic [CountW-1:0]      count;
  } acc_t;

  // Finished statistics from the sequencer
  typedef struct packed {
    logic                      done;
    logic signed [SampleW-1:0] mean;
    logic [SampleW-1:0]        std_dev;
  } seq_res_t;

endpackage

// File: rtl/core/mean_and_std_dev_accumulator.sv
// Mean and sample standard deviation of a stream of signed Q16.8 samples.
// Input channel (in_valid_i / in_stall_o): one sample per transfer. Samples with
// sample_valid_i low are skipped; beyond 65536 valid samples further ones are dropped.
// Items without last_sample_i are taken one per cycle while the input is not stalled and give no result.
// A transfer with last_sample_i high ends the sequence. The block then stalls its
// input and runs one add/subtract unit under a sequencer: n*S2, S1^2, difference,
// n*(n-1), variance divide, square root and mean divide. With one valid sample only
// the mean divide runs; with none both statistics are zero. The input is ready
// again in the cycle the result shows up.
// Output channel (out_valid_o / out_stall_i): one result transfer per sequence from
// an output register. While the receiver stalls, the result holds and a newer
// result waits in the sequencer; the input stays stalled until it is handed over.
// The sums clear once a result is handed to the output register.
// Reset (rst_ni low) clears the sums, the sequencer and the output valid.
`include "mean_and_std_dev_accumulator_macros.svh"

module mean_and_std_dev_accumulator import msd_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [SampleW-1:0] sample_i,
  input  logic                      sample_valid_i,
  input  logic                      last_sample_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [SampleW-1:0] mean_o,
  output logic [SampleW-1:0]        std_dev_o,
  output logic [CountW-1:0]         valid_count_o,
  output logic                      mean_defined_o
);

  acc_t     acc;
  seq_res_t seq_res;
  logic     busy;
  logic     in_xfer;
  logic     res_ready;

  logic                      out_valid_q, out_valid_d;
  logic signed [SampleW-1:0] mean_q;
  logic [SampleW-1:0]        std_dev_q;
  logic [CountW-1:0]         count_q;
  logic                      defined_q;

  assign in_stall_o = busy;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign res_ready  = !out_valid_q || !out_stall_i;

  msd_accum u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .add_i    (in_xfer && sample_valid_i),
    .sample_i (sample_i),
    .clear_i  (seq_res.done),
    .acc_o    (acc)
  );

  msd_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_xfer && last_sample_i),
    .res_ready_i (res_ready),
    .acc_i       (acc),
    .busy_o      (busy),
    .res_o       (seq_res)
  );

  // Output register: load a finished result, drop valid once transferred
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (seq_res.done) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_res.done) begin
      mean_q    <= seq_res.mean;
      std_dev_q <= seq_res.std_dev;
      count_q   <= acc.count;
      defined_q <= |acc.count;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign mean_o         = mean_q;
  assign std_dev_o      = std_dev_q;
  assign valid_count_o  = count_q;
  assign mean_defined_o = defined_q;

  `MSD_ASSERT_NEXT(a_last_stalls_input, clk_i, rst_ni, in_valid_i && !in_stall_o && last_sample_i, in_stall_o, "input not stalled after last transfer")
  `MSD_ASSERT_NEXT(a_sums_clear_after_result, clk_i, rst_ni, seq_res.done, acc.count == '0, "sums not cleared after result")
  `MSD_ASSERT_IMPL(a_dev_zero_small_count, clk_i, rst_ni, out_valid_o && (valid_count_o < CountW'(2)), std_dev_o == '0, "deviation nonzero with fewer than two samples")

endmodule

// File: rtl/core/msd_accum.sv
module msd_accum import msd_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      add_i,
  input  logic signed [SampleW-1:0] sample_i,
  input  logic                      clear_i,
  output acc_t                      acc_o
);

  acc_t                      acc_q, acc_d;
  logic signed [SquareW-1:0] square;

  assign square = sample_i * sample_i;

  // Add a valid sample unless the sequence is full; clear after a result
  always_comb begin
    acc_d = acc_q;
    if (clear_i) begin
      acc_d = '0;
    end else if (add_i && (acc_q.count < MaxSamples)) begin
      acc_d.sum    = acc_q.sum + SumW'(sample_i);
      acc_d.sq_sum = acc_q.sq_sum + SqSumW'($unsigned(square));
      acc_d.count  = acc_q.count + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

// File: rtl/core/msd_addsub.sv
module msd_addsub import msd_pkg::*; (
  input  logic [WideW-1:0] a_i,
  input  logic [WideW-1:0] b_i,
  input  logic             sub_i,
  output logic [WideW-1:0] res_o,
  output logic             carry_o
);

  logic [WideW:0]   full;
  logic [WideW-1:0] b_eff;

  // Subtract as add of the complement; carry out high means no borrow
  assign b_eff = sub_i ? ~b_i : b_i;
  assign full  = {1'b0, a_i} + {1'b0, b_eff} + {{WideW{1'b0}}, sub_i};

  assign res_o   = full[WideW-1:0];
  assign carry_o = full[WideW];

endmodule

// File: rtl/core/msd_seq.sv
module msd_seq import msd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  logic     res_ready_i,
  input  acc_t     acc_i,
  output logic     busy_o,
  output seq_res_t res_o
);

  seq_state_e         state_q, state_d;
  logic [IterW-1:0]   iter_q, iter_d;
  logic [WideW-1:0]   work_q, work_d;
  logic [WideW-1:0]   opnd_q, opnd_d;
  logic [SumW-1:0]    mplr_q, mplr_d;
  logic [SumW-1:0]    mag_q, mag_d;
  logic [WideW-1:0]   num_q, num_d;
  logic [DenW-1:0]    den_q, den_d;
  logic [DenW-1:0]    rem_q, rem_d;
  logic [RootW-1:0]   root_q, root_d;
  logic [SampleW-1:0] mean_q, mean_d;
  logic [SampleW-1:0] dev_q, dev_d;

  // Shared unit ports
  logic [WideW-1:0] add_a, add_b, add_res;
  logic             add_sub, add_carry;

  logic               last_iter;
  logic [WideW-1:0]   mul_sum;
  logic [DenW:0]      rem_sh;
  logic [DenW-1:0]    rem_next;
  logic [WideW-1:0]   work_div;
  logic [RootW-1:0]   var_sat;
  logic [RootW-1:0]   root_next;
  logic [SampleW-1:0] dev_sat;
  logic [SampleW-1:0] quo;
  logic [SumW-1:0]    load_mag;
  logic               sum_neg;

  msd_addsub u_addsub (
    .a_i     (add_a),
    .b_i     (add_b),
    .sub_i   (add_sub),
    .res_o   (add_res),
    .carry_o (add_carry)
  );

  // Route operands of the shared unit by phase
  always_comb begin
    add_a   = work_q;
    add_b   = opnd_q;
    add_sub = 1'b0;
    case (state_q)
      SeqLoad: begin
        add_a   = '0;
        add_b   = WideW'(acc_i.sum);
        add_sub = 1'b1;
      end
      SeqDiff: begin
        add_a   = num_q;
        add_b   = work_q;
        add_sub = 1'b1;
      end
      SeqDivVar, SeqDivMean: begin
        add_a   = WideW'(rem_sh);
        add_b   = WideW'(den_q);
        add_sub = 1'b1;
      end
      SeqRoot: begin
        add_a   = work_q;
        add_b   = WideW'(root_q | opnd_q[RootW-1:0]);
        add_sub = 1'b1;
      end
      default: begin
        add_a   = work_q;
        add_b   = opnd_q;
        add_sub = 1'b0;
      end
    endcase
  end

  // Step results shared by the phases
  assign last_iter = (iter_q == IterW'(1));
  assign mul_sum   = mplr_q[0] ? add_res : work_q;
  assign rem_sh    = {rem_q, work_q[WideW-1]};
  assign rem_next  = add_carry ? add_res[DenW-1:0] : rem_sh[DenW-1:0];
  assign work_div  = {work_q[WideW-2:0], add_carry};
  assign var_sat   = (|work_div[WideW-1:RootW]) ? '1 : work_div[RootW-1:0];
  assign root_next = add_carry ? ((root_q >> 1) | opnd_q[RootW-1:0]) : (root_q >> 1);
  assign dev_sat   = (|root_next[RootW-1:SampleW]) ? '1 : root_next[SampleW-1:0];
  assign quo       = work_div[SampleW-1:0];
  assign sum_neg   = acc_i.sum[SumW-1];
  assign load_mag  = sum_neg ? add_res[SumW-1:0] : $unsigned(acc_i.sum);

  // Sequence the phases: products, difference, denominator product, divide, root, mean divide
  always_comb begin
    state_d = state_q;
    iter_d  = iter_q;
    work_d  = work_q;
    opnd_d  = opnd_q;
    mplr_d  = mplr_q;
    mag_d   = mag_q;
    num_d   = num_q;
    den_d   = den_q;
    rem_d   = rem_q;
    root_d  = root_q;
    mean_d  = mean_q;
    dev_d   = dev_q;
    res_o   = '0;
    case (state_q)
      SeqIdle: begin
        if (start_i) begin
          state_d = SeqLoad;
        end
      end
      SeqLoad: begin
        mag_d = load_mag;
        if (acc_i.count == '0) begin
          mean_d  = '0;
          dev_d   = '0;
          state_d = SeqDone;
        end else if (acc_i.count == CountW'(1)) begin
          dev_d   = '0;
          work_d  = {load_mag, {(WideW-SumW){1'b0}}};
          rem_d   = '0;
          den_d   = DenW'(acc_i.count);
          iter_d  = DivMeanIters;
          state_d = SeqDivMean;
        end else begin
          work_d  = '0;
          opnd_d  = WideW'(acc_i.sq_sum);
          mplr_d  = SumW'(acc_i.count);
          iter_d  = MulCountIters;
          state_d = SeqMulN;
        end
      end
      SeqMulN, SeqMulSq, SeqMulDen: begin
        work_d = mul_sum;
        opnd_d = opnd_q << 1;
        mplr_d = mplr_q >> 1;
        iter_d = iter_q - 1'b1;
        if (last_iter) begin
          if (state_q == SeqMulN) begin
            num_d   = mul_sum;
            work_d  = '0;
            opnd_d  = WideW'(mag_q);
            mplr_d  = mag_q;
            iter_d  = SqIters;
            state_d = SeqMulSq;
          end else if (state_q == SeqMulSq) begin
            state_d = SeqDiff;
          end else begin
            den_d   = mul_sum[DenW-1:0];
            work_d  = num_q;
            rem_d   = '0;
            iter_d  = DivVarIters;
            state_d = SeqDivVar;
          end
        end
      end
      SeqDiff: begin
        num_d   = add_res;
        work_d  = '0;
        opnd_d  = WideW'(acc_i.count);
        mplr_d  = SumW'(acc_i.count - 1'b1);
        iter_d  = MulCountIters;
        state_d = SeqMulDen;
      end
      SeqDivVar: begin
        work_d = work_div;
        rem_d  = rem_next;
        iter_d = iter_q - 1'b1;
        if (last_iter) begin
          work_d  = WideW'(var_sat);
          opnd_d  = WideW'(RootFirstBit);
          root_d  = '0;
          iter_d  = RootIters;
          state_d = SeqRoot;
        end
      end
      SeqRoot: begin
        if (add_carry) begin
          work_d = add_res;
        end
        root_d = root_next;
        opnd_d = opnd_q >> 2;
        iter_d = iter_q - 1'b1;
        if (last_iter) begin
          dev_d   = dev_sat;
          work_d  = {mag_q, {(WideW-SumW){1'b0}}};
          rem_d   = '0;
          den_d   = DenW'(acc_i.count);
          iter_d  = DivMeanIters;
          state_d = SeqDivMean;
        end
      end
      SeqDivMean: begin
        work_d = work_div;
        rem_d  = rem_next;
        iter_d = iter_q - 1'b1;
        if (last_iter) begin
          mean_d  = sum_neg ? (SampleW'(0) - quo) : quo;
          state_d = SeqDone;
        end
      end
      SeqDone: begin
        // Hold until the output register can take the result
        if (res_ready_i) begin
          res_o.done = 1'b1;
          state_d    = SeqIdle;
        end
      end
      default: begin
        state_d = SeqIdle;
      end
    endcase
    res_o.mean    = $signed(mean_q);
    res_o.std_dev = dev_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SeqIdle;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    opnd_q <= opnd_d;
    mplr_q <= mplr_d;
    mag_q  <= mag_d;
    num_q  <= num_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    mean_q <= mean_d;
    dev_q  <= dev_d;
  end

  assign busy_o = (state_q != SeqIdle);

endmodule

// File: test/mean_and_std_dev_accumulator_tb.sv
`timescale 1ns / 100ps

import msd_pkg::*;

// Expected statistics of one finished sequence
typedef struct {
  logic signed [SampleW-1:0] mean;
  logic [SampleW-1:0]        std_dev;
  logic [CountW-1:0]         count;
  logic                      defined;
} seq_stats_t;

class stats_scoreboard;
  logic signed [SumW-1:0] run_sum;
  logic [SqSumW-1:0]      run_sq;
  logic [CountW-1:0]      run_n;
  seq_stats_t             expected_stats[$];
  int                     errors;
  int                     results_checked;

  function new();
    run_sum = '0;
    run_sq = '0;
    run_n = '0;
    errors = 0;
    results_checked = 0;
  endfunction

  function int pending();
    return expected_stats.size();
  endfunction

  // Accumulate one accepted sample; on the last one queue the sequence statistics
  function void note_sample(logic signed [SampleW-1:0] x, logic ok, logic last);
    seq_stats_t             st;
    logic signed [SquareW-1:0] sq;
    logic signed [SumW-1:0] n_s;
    logic signed [SumW-1:0] quot;
    logic [SumW-1:0]        mag;
    logic [127:0]           num;
    logic [127:0]           den;
    logic [127:0]           var_w;
    logic [63:0]            v;
    logic [63:0]            root;
    logic [63:0]            trial;
    if (ok && run_n < MaxSamples) begin
      sq = x * x;
      run_sum = run_sum + x;
      run_sq = run_sq + {{(SqSumW-SquareW){1'b0}}, sq};
      run_n = run_n + 1'b1;
    end
    if (!last) return;

    st.mean = '0;
    st.std_dev = '0;
    st.count = run_n;
    st.defined = (run_n != 0);
    if (run_n != 0) begin
      n_s = SumW'(run_n);
      quot = run_sum / n_s;
      st.mean = quot[SampleW-1:0];
    end
    if (run_n > 1) begin
      mag = (run_sum < 0) ? -run_sum : run_sum;
      num = 128'(run_n) * 128'(run_sq) - 128'(mag) * 128'(mag);
      den = 128'(run_n);
      den = den * (den - 1);
      var_w = num / den;
      v = (var_w[127:64] != 0) ? '1 : var_w[63:0];
      // Bitwise integer square root, floor
      root = '0;
      trial = 64'd1 << 62;
      while (trial > v) trial = trial >> 2;
      while (trial != 0) begin
        if (v >= root + trial) begin
          v = v - (root + trial);
          root = (root >> 1) + trial;
        end else begin
          root = root >> 1;
        end
        trial = trial >> 2;
      end
      st.std_dev = (root > 64'hFF_FFFF) ? '1 : root[SampleW-1:0];
    end
    expected_stats.push_back(st);
    run_sum = '0;
    run_sq = '0;
    run_n = '0;
  endfunction

  // Compare one result transfer against the oldest expectation
  function void check_result(logic signed [SampleW-1:0] mean, logic [SampleW-1:0] std_dev,
                             logic [CountW-1:0] count, logic defined);
    seq_stats_t st;
    if (expected_stats.size() == 0) begin
      $display("%0t: unexpected result mean=%0d std_dev=%0d count=%0d defined=%0b",
               $time, mean, std_dev, count, defined);
      errors++;
      return;
    end
    st = expected_stats.pop_front();
    results_checked++;
    if (mean !== st.mean) begin
      $display("%0t: mean expected %0d actual %0d", $time, st.mean, mean);
      errors++;
    end
    if (std_dev !== st.std_dev) begin
      $display("%0t: std_dev expected %0d actual %0d", $time, st.std_dev, std_dev);
      errors++;
    end
    if (count !== st.count) begin
      $display("%0t: valid_count expected %0d actual %0d", $time, st.count, count);
      errors++;
    end
    if (defined !== st.defined) begin
      $display("%0t: mean_defined expected %0b actual %0b", $time, st.defined, defined);
      errors++;
    end
  endfunction
endclass

module mean_and_std_dev_accumulator_tb;

  typedef enum int {StallNone, StallRandom, StallHold} stall_mode_e;

  localparam logic signed [SampleW-1:0] SampleMax = 24'sh7F_FFFF;
  localparam logic signed [SampleW-1:0] SampleMin = 24'sh80_0000;
  localparam int RandomItems = 630;
  localparam int DrainCycles = 300;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic signed [SampleW-1:0] sample_i = '0;
  logic                      sample_valid_i = 1'b0;
  logic                      last_sample_i = 1'b0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic signed [SampleW-1:0] mean_o;
  logic [SampleW-1:0]        std_dev_o;
  logic [CountW-1:0]         valid_count_o;
  logic                      mean_defined_o;

  stats_scoreboard sb = new();

  int          items_sent = 0;
  int          burst_left = 0;
  bit          idle_on = 1'b0;
  int          stall_left = 0;
  stall_mode_e stall_mode = StallNone;

  mean_and_std_dev_accumulator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_i       (sample_i),
    .sample_valid_i (sample_valid_i),
    .last_sample_i  (last_sample_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .mean_o         (mean_o),
    .std_dev_o      (std_dev_o),
    .valid_count_o  (valid_count_o),
    .mean_defined_o (mean_defined_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver stall pattern: segments of free flow, random stalls and long holds
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 2));
      stall_left = $urandom_range(20, 400);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      StallNone:   out_stall_i <= 1'b0;
      StallRandom: out_stall_i <= ($urandom_range(0, 1) == 1);
      default:     out_stall_i <= 1'b1;
    endcase
  end

  // Watch both channels for transfers
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        sb.note_sample(sample_i, sample_valid_i, last_sample_i);
      if (out_valid_o && !out_stall_i)
        sb.check_result(mean_o, std_dev_o, valid_count_o, mean_defined_o);
    end
  end

  // Present one item, hold it until the transfer, then maybe go idle
  task automatic send_item(input logic signed [SampleW-1:0] x, input logic ok,
                           input logic last);
    in_valid_i <= 1'b1;
    sample_i <= x;
    sample_valid_i <= ok;
    last_sample_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
    if (idle_on) begin
      if (burst_left == 0) begin
        // Junk payload while idle must be ignored
        in_valid_i <= 1'b0;
        sample_i <= SampleW'($urandom);
        sample_valid_i <= 1'($urandom_range(0, 1));
        last_sample_i <= 1'($urandom_range(0, 1));
        if ($urandom_range(0, 9) == 0)
          repeat ($urandom_range(50, 300)) @(posedge clk_i);
        else
          repeat ($urandom_range(1, 12)) @(posedge clk_i);
        burst_left = $urandom_range(1, 20);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Drop valid and hold off until every queued result has come back
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [SampleW-1:0] pick_sample();
    case ($urandom_range(0, 4))
      0: return SampleW'($urandom);
      1: return SampleW'($signed($urandom_range(0, 510)) - 255);
      2: return ($urandom_range(0, 1) == 1) ? SampleMax : SampleMin;
      3: return SampleW'($signed($urandom_range(0, 4000)) + 32'sd1_000_000);
      default: return SampleW'($urandom);
    endcase
  endfunction

  // One sequence with random length, validity mix and content
  task automatic random_sequence(inout int counted);
    int len;
    int valid_pct;
    logic ok;
    logic last;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    case ($urandom_range(0, 9))
      0:       valid_pct = 0;
      1, 2:    valid_pct = 50;
      3, 4:    valid_pct = 90;
      default: valid_pct = 100;
    endcase
    for (int i = 0; i < len; i++) begin
      ok = ($urandom_range(1, 100) <= valid_pct);
      last = (i == len - 1);
      send_item(pick_sample(), ok, last);
      counted++;
    end
  endtask

  initial begin
    int counted;
    int next_drain;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: single extreme samples
    send_item(SampleMax, 1'b1, 1'b1);
    send_item(SampleMin, 1'b1, 1'b1);
    // No valid samples at all
    send_item(SampleMax, 1'b0, 1'b1);
    send_item(24'sd5, 1'b0, 1'b0);
    send_item(SampleMin, 1'b0, 1'b0);
    send_item(24'sd0, 1'b0, 1'b1);
    // Largest spread
    send_item(SampleMax, 1'b1, 1'b0);
    send_item(SampleMin, 1'b1, 1'b1);
    // Invalid last item still ends the sequence
    send_item(24'sh100, 1'b1, 1'b0);
    send_item(24'sh300, 1'b1, 1'b0);
    send_item(SampleMax, 1'b0, 1'b1);
    // Negative mean truncates toward zero
    send_item(-24'sd1, 1'b1, 1'b0);
    send_item(-24'sd2, 1'b1, 1'b1);
    // Zeros
    send_item(24'sd0, 1'b1, 1'b0);
    send_item(24'sd0, 1'b1, 1'b1);
    // Mixed signs with a skipped sample inside
    send_item(-24'sd700, 1'b1, 1'b0);
    send_item(SampleMin, 1'b0, 1'b0);
    send_item(24'sd1200, 1'b1, 1'b0);
    send_item(24'sd77, 1'b1, 1'b1);
    wait_for_results();

    // Random sequences, idling switched on and off in stretches
    counted = 0;
    next_drain = 150;
    while (counted < RandomItems) begin
      if ($urandom_range(0, 15) == 0) idle_on = ~idle_on;
      random_sequence(counted);
      if (counted >= next_drain) begin
        wait_for_results();
        next_drain += 150;
      end
    end

    wait_for_results();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d input transfers and %0d checked results, with empty and",
             items_sent, sb.results_checked);
    $display("one-sample sequences, invalid last items, extreme samples and long output stalls.");
    if (sb.errors == 0 && sb.pending() == 0)
      $display("mean_and_std_dev_accumulator_tb OK");
    else
      $display("mean_and_std_dev_accumulator_tb NOT OK");
    $finish;
  end

  // Stop a hung run
  initial begin
    #10_000_000;
    $display("Timeout with %0d results still pending", sb.pending());
    $display("mean_and_std_dev_accumulator_tb NOT OK");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/msd_pkg.sv
rtl/core/msd_accum.sv
rtl/core/msd_addsub.sv
rtl/core/msd_seq.sv
rtl/core/mean_and_std_dev_accumulator.sv
test/mean_and_std_dev_accumulator_tb.sv
